// ----- hdl/ktlw_pkg.sv -----
// Shared types, codes and constants of the kerned text line width block.
`default_nettype none

package ktlw_pkg;

    // Default sizes of the kerning pair store and the glyph width store
    localparam int KERN_ENTRIES_DEF = 64;
    localparam int GLYPH_SLOTS_DEF  = 256;

    // Request operation codes
    localparam logic [1:0] OP_WIDTH = 2'd0;
    localparam logic [1:0] OP_KERN  = 2'd1;
    localparam logic [1:0] OP_TEXT  = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_FIRST_CODE   = 3'd0;
    localparam logic [2:0] CFG_LAST_CODE    = 3'd1;
    localparam logic [2:0] CFG_FIXED_WIDTH  = 3'd2;
    localparam logic [2:0] CFG_PROPORTIONAL = 3'd3;
    localparam logic [2:0] CFG_KERNED       = 3'd4;
    localparam logic [2:0] CFG_KERN_COUNT   = 3'd5;
    localparam logic [2:0] CFG_GLYPH_SCALE  = 3'd6;
    localparam logic [2:0] CFG_LINE_SCALE   = 3'd7;

    // Special text bytes
    localparam logic [7:0] CH_END     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_CODE_OP = 8'h03;  // colour codes up to here take an operand
    localparam logic [7:0] CH_CODE_HI = 8'h06;  // last colour code

    localparam logic [19:0] SUM_MAX  = 20'hFFFFF;
    localparam logic [15:0] LINE_MAX = 16'hFFFF;
    localparam int          KCNT_W   = 7;

    // Search request travelling down the kerning cell chain
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [7:0]        first;
        logic [7:0]        second;
        logic [7:0]        spacing;
        logic [KCNT_W-1:0] remaining;
    } t_token;

endpackage

`default_nettype wire

// ----- hdl/kerned_text_line_width_unit.sv -----
// Top level of the kerned text line width unit.
//
// Usage: requests arrive on the input channel (i_in_valid / o_in_stall). Op 0 loads one
// glyph width, op 1 loads one kerning pair into its cell, op 2 feeds one text byte,
// op 3 is dropped. A zero or newline byte closes the line and one result (the scaled,
// saturated width) leaves on the output channel (o_out_valid / i_out_stall).
// Configuration registers are written through i_cfg_valid / o_cfg_ready, index and data;
// the user must write them only while the unit is idle (not enforced); the port is always ready.
//
// Steps: loads, op 3 and a nonzero colour operand byte complete in S_IDLE. A text byte
// with no glyph held passes S_TAIL. A byte that retires a held glyph passes S_BASE,
// S_SCALE, S_ADD and S_TAIL, plus S_SEARCH when the kerning lookup runs, since the search
// request walks the whole cell chain, one cell per cycle. A line end adds S_LINE and S_LSAT
// for line scaling multiply and saturation; the result is then registered on the output.
// Reset (synchronous, active low) returns every configuration register to its default
// and clears the line state; the glyph and kerning stores keep undefined contents until
// loaded. A stalled result stays in the output register while further requests are
// accepted; only a later line end waits for it to drain.
`default_nettype none

module kerned_text_line_width_unit #(
    parameter int KERN_ENTRIES = ktlw_pkg::KERN_ENTRIES_DEF,
    parameter int GLYPH_SLOTS  = ktlw_pkg::GLYPH_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request channel
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [7:0]  i_slot,
    input  wire logic [8:0]  i_glyph_width,
    input  wire logic [7:0]  i_pair_first,
    input  wire logic [7:0]  i_pair_second,
    input  wire logic [7:0]  i_pair_spacing,
    input  wire logic [7:0]  i_text_byte,
    // result channel
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [15:0]      o_line_width,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    localparam int GAW = (GLYPH_SLOTS > 1) ? $clog2(GLYPH_SLOTS) : 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_BASE   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_SCALE  = 3'd3;
    localparam logic [2:0] S_ADD    = 3'd4;
    localparam logic [2:0] S_TAIL   = 3'd5;
    localparam logic [2:0] S_LINE   = 3'd6;
    localparam logic [2:0] S_LSAT   = 3'd7;

    // Configuration registers
    logic [7:0]  r_first_code;
    logic [7:0]  r_last_code;
    logic [8:0]  r_fixed_width;
    logic        r_proportional;
    logic        r_kerned;
    logic [6:0]  r_kern_count;
    logic [11:0] r_glyph_scale;
    logic [11:0] r_line_scale;

    // Line state and sequencer
    logic [2:0]  r_state, n_state;
    logic [7:0]  r_held, n_held;
    logic        r_held_valid, n_held_valid;
    logic        r_skip, n_skip;
    logic [19:0] r_sum, n_sum;
    logic        r_out_valid, n_out_valid;

    // Datapath registers
    logic [7:0]  r_byte, n_byte;
    logic [8:0]  r_adv, n_adv;
    logic [20:0] r_prod, n_prod;
    logic [31:0] r_lprod, n_lprod;
    logic [15:0] r_out_data, n_out_data;

    logic        w_accept;
    logic        w_text;
    logic [7:0]  w_held_idx;
    logic        w_held_in;
    logic [7:0]  w_byte_idx;
    logic        w_byte_in;
    logic [8:0]  w_ram_rdata;
    logic [8:0]  w_base;
    logic        w_need_kern;
    logic [6:0]  w_kern_n;
    logic [21:0] w_rounded;
    logic [20:0] w_sum_wide;
    logic [32:0] w_line_round;
    logic [24:0] w_line_w;

    ktlw_pkg::t_token w_tok [KERN_ENTRIES+1];

    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_text      = w_accept && (i_op == ktlw_pkg::OP_TEXT);
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_line_width = r_out_data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_code   <= 8'd32;
            r_last_code    <= 8'd127;
            r_fixed_width  <= 9'd8;
            r_proportional <= 1'b0;
            r_kerned       <= 1'b0;
            r_kern_count   <= 7'd0;
            r_glyph_scale  <= 12'd256;
            r_line_scale   <= 12'd256;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ktlw_pkg::CFG_FIRST_CODE:   r_first_code   <= i_cfg_data[7:0];
                ktlw_pkg::CFG_LAST_CODE:    r_last_code    <= i_cfg_data[7:0];
                ktlw_pkg::CFG_FIXED_WIDTH:  r_fixed_width  <= i_cfg_data[8:0];
                ktlw_pkg::CFG_PROPORTIONAL: r_proportional <= i_cfg_data[0];
                ktlw_pkg::CFG_KERNED:       r_kerned       <= i_cfg_data[0];
                ktlw_pkg::CFG_KERN_COUNT:   r_kern_count   <= i_cfg_data[6:0];
                ktlw_pkg::CFG_GLYPH_SCALE:  r_glyph_scale  <= i_cfg_data;
                ktlw_pkg::CFG_LINE_SCALE:   r_line_scale   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Glyph indexes of the held glyph and of the byte that follows it
    assign w_held_idx = r_held - r_first_code;
    assign w_held_in  = (r_held >= r_first_code) && (r_held <= r_last_code);
    assign w_byte_idx = r_byte - r_first_code;
    assign w_byte_in  = (r_byte >= r_first_code) && (r_byte <= r_last_code);

    // Glyph width store: written by width loads, read as the text byte is taken
    ktlw_ram #(
        .WIDTH (9),
        .DEPTH (GLYPH_SLOTS),
        .AW    (GAW)
    ) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_op == ktlw_pkg::OP_WIDTH)
                  && ({1'b0, i_slot} < 9'(GLYPH_SLOTS))),
        .i_waddr (i_slot[GAW-1:0]),
        .i_wdata (i_glyph_width),
        .i_re    (w_text),
        .i_raddr (w_held_idx[GAW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Advance before kerning; a glyph outside the font counts as a space
    always_comb begin
        if (!w_held_in) begin
            w_base = r_proportional ? {1'b0, r_fixed_width[8:1]} : r_fixed_width;
        end else if (r_proportional) begin
            w_base = ({1'b0, w_held_idx} < 9'(GLYPH_SLOTS)) ? w_ram_rdata : 9'd0;
        end else begin
            w_base = r_fixed_width;
        end
    end

    assign w_need_kern = r_kerned && (r_byte != ktlw_pkg::CH_END)
                      && (r_byte != ktlw_pkg::CH_NEWLINE) && w_byte_in && w_held_in;
    assign w_kern_n    = (32'(r_kern_count) <= KERN_ENTRIES) ? r_kern_count
                                                           : 7'(KERN_ENTRIES);

    // Launch the search request into the head of the chain
    always_comb begin
        w_tok[0]           = '0;
        w_tok[0].valid     = (r_state == S_BASE) && w_need_kern;
        w_tok[0].first     = w_held_idx;
        w_tok[0].second    = w_byte_idx;
        w_tok[0].remaining = w_kern_n;
    end

    // Kerning pair chain: one entry per cell, request advances one cell a cycle
    for (genvar g = 0; g < KERN_ENTRIES; g++) begin : g_cell
        ktlw_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_we      (w_accept && (i_op == ktlw_pkg::OP_KERN)
                        && (32'(i_slot) == 32'(g))),
            .i_first   (i_pair_first),
            .i_second  (i_pair_second),
            .i_spacing (i_pair_spacing),
            .i_tok     (w_tok[g]),
            .o_tok     (w_tok[g+1])
        );
    end

    assign w_rounded    = 22'(r_prod) + 22'd128;
    assign w_sum_wide   = {1'b0, r_sum} + 21'(w_rounded[21:8]);
    assign w_line_round = 33'(r_lprod) + 33'd128;
    assign w_line_w     = w_line_round[32:8];

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_held_valid = r_held_valid;
        n_skip       = r_skip;
        n_sum        = r_sum;
        n_out_valid  = r_out_valid;
        n_byte       = r_byte;
        n_adv        = r_adv;
        n_prod       = r_prod;
        n_lprod      = r_lprod;
        n_out_data   = r_out_data;

        // Drop the result once the receiver has taken it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_text) begin
                    n_byte = i_text_byte;
                    if (r_skip) begin
                        // operand of a colour code: only a zero byte still ends the line
                        n_skip = 1'b0;
                        if (i_text_byte == ktlw_pkg::CH_END) begin
                            n_state = S_LINE;
                        end
                    end else if (r_held_valid) begin
                        n_state = S_BASE;
                    end else begin
                        n_state = S_TAIL;
                    end
                end
            end
            S_BASE: begin
                n_adv   = w_base;
                n_state = w_need_kern ? S_SEARCH : S_SCALE;
            end
            S_SEARCH: begin
                if (w_tok[KERN_ENTRIES].valid) begin
                    if (w_tok[KERN_ENTRIES].found) begin
                        n_adv = {1'b0, w_tok[KERN_ENTRIES].spacing};
                    end
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_prod  = 21'(r_adv) * 21'(r_glyph_scale);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sum        = w_sum_wide[20] ? ktlw_pkg::SUM_MAX : w_sum_wide[19:0];
                n_held       = 8'd0;
                n_held_valid = 1'b0;
                n_state      = S_TAIL;
            end
            S_TAIL: begin
                if ((r_byte == ktlw_pkg::CH_END) || (r_byte == ktlw_pkg::CH_NEWLINE)) begin
                    n_state = S_LINE;
                end else if (r_byte <= ktlw_pkg::CH_CODE_HI) begin
                    if (r_byte <= ktlw_pkg::CH_CODE_OP) begin
                        n_skip = 1'b1;
                    end
                    n_state = S_IDLE;
                end else begin
                    n_held       = r_byte;
                    n_held_valid = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_LINE: begin
                n_lprod      = 32'(r_sum) * 32'(r_line_scale);
                n_sum        = 20'd0;
                n_held       = 8'd0;
                n_held_valid = 1'b0;
                n_skip       = 1'b0;
                n_state      = S_LSAT;
            end
            S_LSAT: begin
                // Hold until the output register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    n_out_data  = (w_line_w > 25'(ktlw_pkg::LINE_MAX))
                                ? ktlw_pkg::LINE_MAX : w_line_w[15:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_held       <= 8'd0;
            r_held_valid <= 1'b0;
            r_skip       <= 1'b0;
            r_sum        <= 20'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
            r_skip       <= n_skip;
            r_sum        <= n_sum;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_adv      <= n_adv;
        r_prod     <= n_prod;
        r_lprod    <= n_lprod;
        r_out_data <= n_out_data;
    end

    // A search request leaves the chain only while the sequencer waits for it
    a_tok_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tok[KERN_ENTRIES].valid |-> (r_state == S_SEARCH))
        else $error("kerning search result outside the search phase");

    // A new result only comes from the saturation step
    a_out_from_lsat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_LSAT))
        else $error("result raised outside the line finish");

    // A held glyph and a pending colour operand never coexist
    a_held_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_held_valid && r_skip))
        else $error("held glyph while a colour operand is pending");

    // Closing a line clears the line state
    a_line_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LINE) |=> ((r_sum == 20'd0) && !r_held_valid && !r_skip))
        else $error("line state not cleared at line end");

endmodule

`default_nettype wire

// ----- hdl/ktlw_ram.sv -----
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module ktlw_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ktlw_cell.sv -----
// One kerning pair cell: holds one entry and tests the passing search request.
`default_nettype none

module ktlw_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_we,
    input  wire logic [7:0]      i_first,
    input  wire logic [7:0]      i_second,
    input  wire logic [7:0]      i_spacing,
    input  wire ktlw_pkg::t_token i_tok,
    output ktlw_pkg::t_token     o_tok
);

    logic [7:0]       r_first;
    logic [7:0]       r_second;
    logic [7:0]       r_spacing;
    logic             w_hit;
    ktlw_pkg::t_token n_tok;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_first   <= i_first;
            r_second  <= i_second;
            r_spacing <= i_spacing;
        end
    end

    // Only the first matching entry within the searched count may answer
    assign w_hit = i_tok.valid && !i_tok.found && (i_tok.remaining != '0)
                && (r_first == i_tok.first) && (r_second == i_tok.second);

    always_comb begin
        n_tok = i_tok;
        n_tok.found = i_tok.found || w_hit;
        if (w_hit) begin
            n_tok.spacing = r_spacing;
        end
        if (i_tok.remaining != '0) begin
            n_tok.remaining = i_tok.remaining - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_tok <= '0;
        end else begin
            o_tok <= n_tok;
        end
    end

endmodule

`default_nettype wire
